@@ sv/sorted_list_insert_delete_core_assert.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the sorted list core
// Immediate-looking wrappers around concurrent properties on clk / rst_n.
// ----------------------------------------------------------------------------
`ifndef SORTED_LIST_INSERT_DELETE_CORE_ASSERT_SVH
`define SORTED_LIST_INSERT_DELETE_CORE_ASSERT_SVH

`ifndef SYNTHESIS
// check cond on every edge outside reset
`define SLI_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) else $error(msg);
// check post in the cycle after pre
`define SLI_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) else $error(msg);
`else
`define SLI_ASSERT_ALWAYS(lbl, cond, msg)
`define SLI_ASSERT_NEXT(lbl, pre, post, msg)
`endif

`endif

@@ sv/sli_pkg.sv @@
// ----------------------------------------------------------------------------
// sli_pkg
// Shared types and codes of the sorted list core.
// ----------------------------------------------------------------------------
package sli_pkg;

  localparam int unsigned VAL_W = 32;

  typedef enum logic {
    CMD_INSERT = 1'b0,
    CMD_DELETE = 1'b1
  } cmd_t;

  typedef enum logic [1:0] {
    ST_DONE      = 2'd0,
    ST_FULL      = 2'd1,
    ST_NOT_FOUND = 2'd2
  } status_t;

  // broadcast from the controller to every cell
  typedef struct packed {
    logic             ins_en;
    logic             del_en;
    logic [VAL_W-1:0] value;
  } cell_ctl_t;

endpackage

@@ sv/sli_cell.sv @@
// ----------------------------------------------------------------------------
// sli_cell
// One slot of the sorted row: compares against the broadcast value and takes
// it, its own, the left or the right neighbor's value on an update.
// ----------------------------------------------------------------------------
module sli_cell
  import sli_pkg::*;
(
  input  logic             clk,
  input  cell_ctl_t        ctl,
  input  logic             valid,
  input  logic [VAL_W-1:0] left_val,
  input  logic             left_lt,
  input  logic [VAL_W-1:0] right_val,
  output logic [VAL_W-1:0] val,
  output logic             lt,
  output logic             eq
);

  logic [VAL_W-1:0] val_r;
  logic [VAL_W-1:0] val_nxt;

  assign lt  = valid && ($signed(val_r) < $signed(ctl.value));
  assign eq  = valid && (val_r == ctl.value);
  assign val = val_r;

  always_comb begin
    val_nxt = val_r;
    if (ctl.ins_en && !lt) begin
      // first slot not below the new value takes it, the rest shift right
      val_nxt = left_lt ? ctl.value : left_val;
    end else if (ctl.del_en && !lt) begin
      val_nxt = right_val;
    end
  end

  always_ff @(posedge clk) begin
    val_r <= val_nxt;
  end

endmodule

@@ sv/sorted_list_insert_delete_core.sv @@
// ----------------------------------------------------------------------------
// sorted_list_insert_delete_core
// Bounded multiset of signed values kept in ascending order in a row of cells.
// ----------------------------------------------------------------------------
//  channel | dir | tdata                          | tuser
//  in_     | in  | value[31:0]                    | command
//  out_    | out | status, entry_count,           | -
//          |     | smallest_value, list_empty     |
//
// One item per cycle unless a result waits untaken: every cell compares
// against the broadcast value in parallel and the whole row shifts at the
// accepting edge; the not-found check is an OR over the per-cell match bits.
// The result is ready the cycle after the item is taken and held until taken.
// A new item is taken at the same edge as the pending result.
// Reset clears count, out_tvalid and status; cells stay undefined until used.
// ----------------------------------------------------------------------------
`include "sorted_list_insert_delete_core_assert.svh"

module sorted_list_insert_delete_core
  import sli_pkg::*;
#(
  parameter int unsigned CAPACITY = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [31:0] in_tdata,   // [31:0] value
  input  logic        in_tuser,   // [0] command
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata   // [1:0] status, [6:2] entry_count,
                                  // [38:7] smallest_value, [39] list_empty
);

  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned XW = (CW > 5) ? CW : 5;

  logic [CW-1:0]    count_r;
  logic [CW-1:0]    count_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;
  status_t          status_r;
  status_t          status_nxt;

  logic             acc;
  logic             is_insert;
  logic             full;
  logic             found;
  cell_ctl_t        ctl;
  logic [CAPACITY-1:0] valid_v;
  logic [CAPACITY-1:0] lt_v;
  logic [CAPACITY-1:0] eq_v;
  logic [VAL_W-1:0] cell_val [CAPACITY];
  logic [XW-1:0]    count_x;

  assign in_tready = !out_valid_r || out_tready;
  assign acc       = in_tvalid && in_tready;
  assign is_insert = (in_tuser == CMD_INSERT);
  assign full      = (count_r == CW'(CAPACITY));
  assign found     = |eq_v;

  assign ctl.value  = in_tdata;
  assign ctl.ins_en = acc && is_insert && !full;
  assign ctl.del_en = acc && !is_insert && found;

  genvar g;
  generate
    for (g = 0; g < CAPACITY; g++) begin : g_cell
      logic [VAL_W-1:0] lv;
      logic             llt;
      logic [VAL_W-1:0] rv;

      assign valid_v[g] = (CW'(g) < count_r);

      if (g == 0) begin : g_first
        assign lv  = in_tdata;
        assign llt = 1'b0;
      end else begin : g_mid
        assign lv  = cell_val[g-1];
        assign llt = lt_v[g-1];
      end

      if (g == CAPACITY - 1) begin : g_last
        assign rv = cell_val[g];
      end else begin : g_body
        assign rv = cell_val[g+1];
      end

      sli_cell u_cell (
        .clk       (clk),
        .ctl       (ctl),
        .valid     (valid_v[g]),
        .left_val  (lv),
        .left_lt   (llt),
        .right_val (rv),
        .val       (cell_val[g]),
        .lt        (lt_v[g]),
        .eq        (eq_v[g])
      );
    end
  endgenerate

  always_comb begin
    count_nxt     = count_r;
    status_nxt    = status_r;
    out_valid_nxt = out_valid_r;
    if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
    if (acc) begin
      out_valid_nxt = 1'b1;
      if (is_insert) begin
        if (full) begin
          status_nxt = ST_FULL;
        end else begin
          status_nxt = ST_DONE;
          count_nxt  = count_r + 1'b1;
        end
      end else begin
        if (found) begin
          status_nxt = ST_DONE;
          count_nxt  = count_r - 1'b1;
        end else begin
          status_nxt = ST_NOT_FOUND;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r     <= '0;
      out_valid_r <= 1'b0;
      status_r    <= ST_DONE;
    end else begin
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  // state only moves when no result waits or it leaves, so read it straight out
  assign count_x           = XW'(count_r);
  assign out_tvalid        = out_valid_r;
  assign out_tdata[1:0]    = status_r;
  assign out_tdata[6:2]    = count_x[4:0];
  assign out_tdata[38:7]   = (count_r == '0) ? '0 : cell_val[0];
  assign out_tdata[39]     = (count_r == '0);

  `SLI_ASSERT_ALWAYS(a_count_bound, count_r <= CW'(CAPACITY), "entry count above capacity")
  `SLI_ASSERT_NEXT(a_full_reject, acc && is_insert && full,
                   status_r == ST_FULL && $stable(count_r), "insert into full list changed state")
  `SLI_ASSERT_NEXT(a_ins_count, ctl.ins_en, count_r == $past(count_r) + 1'b1,
                   "insert did not advance count")
  `SLI_ASSERT_ALWAYS(a_head_sorted,
                     count_r < CW'(2) || $signed(cell_val[0]) <= $signed(cell_val[1]),
                     "first two entries out of order")

endmodule
